@@ design/kevq_pkg.sv @@
// Key event queue package: beat structs, opcodes, event codes, defaults.
// No dependencies.
package kevq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_KEYS_DEF    = 256;

  localparam logic [2:0] OP_KEY_DOWN = 3'd0;
  localparam logic [2:0] OP_KEY_UP   = 3'd1;
  localparam logic [2:0] OP_POP      = 3'd2;
  localparam logic [2:0] OP_FLUSH    = 3'd3;
  localparam logic [2:0] OP_PUSH     = 3'd4;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;
  localparam logic [1:0] EV_BAD  = 2'd3;

  localparam logic [8:0] NO_KEY = 9'h100;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] key_code;
    logic [1:0] push_type;
  } item_t;

  typedef struct packed {
    logic [1:0] event_type;
    logic [8:0] event_key;
    logic       key_pressed;
    logic       queue_empty;
    logic [4:0] queue_count;
    logic       dropped_oldest;
  } result_t;

  typedef struct packed {
    logic [1:0] ev_type;
    logic [8:0] ev_key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

@@ design/kevq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/key_event_queue.sv @@
// Key event queue: per-key pressed bits plus an event queue that drops its oldest entry.
// The item beat is held in an input register; the result beat is registered when it leaves that register.
// Throughput: one item per cycle while the result side is not stalled; input register, one logic pass, result register.
// Reset clears pressed bits, read pointer and count; slot RAM is not cleared.
// Depends on kevq_pkg and kevq_ram.
module key_event_queue
  import kevq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_KEYS    = NUM_KEYS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int KEY_W = $clog2(NUM_KEYS);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
  localparam logic [8:0]       KEY_LIMIT = 9'(NUM_KEYS);

  logic                s1_valid;
  item_t               s1_item;
  logic [NUM_KEYS-1:0] pressed;
  logic [PTR_W-1:0]    rp;
  logic [CNT_W-1:0]    cnt;
  logic                byp_hit;
  slot_t               byp_data;

  logic                s1_fire;
  logic                key_ok;
  logic [KEY_W-1:0]    key_idx;
  logic                pressed_cur;
  logic                pressed_after;
  slot_t               ram_rdata;
  slot_t               head;
  logic                full;
  logic [PTR_W-1:0]    rp_inc;
  logic [PTR_W-1:0]    rp_adv;
  logic [CNT_W-1:0]    cnt_base;
  logic [SUM_W-1:0]    wr_sum;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rp_next;
  logic [CNT_W-1:0]    cnt_next;
  logic [CNT_W+4:0]    cnt_ext;
  logic                enq;
  slot_t               enq_slot;
  logic                set_bit;
  logic                bit_val;
  logic                flush;
  logic                dropped;
  logic [1:0]          ev_type;
  logic [8:0]          ev_key;
  result_t             result_next;

  assign s1_fire     = s1_valid && (!result_valid || result_ready);
  assign item_ready  = !s1_valid || s1_fire;
  assign key_ok      = {1'b0, s1_item.key_code} < KEY_LIMIT;
  assign key_idx     = s1_item.key_code[KEY_W-1:0];
  assign pressed_cur = key_ok && pressed[key_idx];
  assign head        = byp_hit ? byp_data : ram_rdata;

  assign full     = cnt == CNT_FULL;
  assign rp_inc   = (rp == PTR_LAST) ? '0 : rp + 1'b1;
  assign rp_adv   = full ? rp_inc : rp;
  assign cnt_base = full ? CNT_FULL - 1'b1 : cnt;
  assign wr_sum   = SUM_W'(rp_adv) + SUM_W'(cnt_base);
  assign wr_ptr   = (wr_sum >= SUM_DEPTH) ? PTR_W'(wr_sum - SUM_DEPTH) : PTR_W'(wr_sum);

  always_comb begin
    rp_next       = rp;
    cnt_next      = cnt;
    enq           = 1'b0;
    enq_slot      = '0;
    set_bit       = 1'b0;
    bit_val       = 1'b0;
    flush         = 1'b0;
    pressed_after = pressed_cur;
    ev_type       = EV_NONE;
    ev_key        = '0;
    if (s1_fire) begin
      unique case (s1_item.opcode)
        OP_KEY_DOWN: begin
          pressed_after = key_ok;
          if (key_ok && !pressed_cur) begin
            set_bit  = 1'b1;
            bit_val  = 1'b1;
            enq      = 1'b1;
            enq_slot = '{ev_type: EV_DOWN, ev_key: {1'b0, s1_item.key_code}};
          end
        end
        OP_KEY_UP: begin
          pressed_after = 1'b0;
          if (pressed_cur) begin
            set_bit  = 1'b1;
            enq      = 1'b1;
            enq_slot = '{ev_type: EV_UP, ev_key: {1'b0, s1_item.key_code}};
          end
        end
        OP_POP: begin
          if (cnt != '0) begin
            ev_type  = head.ev_type;
            ev_key   = head.ev_key;
            rp_next  = rp_inc;
            cnt_next = cnt - 1'b1;
          end else begin
            ev_key = NO_KEY;
          end
        end
        OP_FLUSH: begin
          flush         = 1'b1;
          rp_next       = '0;
          cnt_next      = '0;
          pressed_after = 1'b0;
        end
        OP_PUSH: begin
          enq      = 1'b1;
          enq_slot = '{ev_type: (s1_item.push_type == EV_BAD) ? EV_NONE : s1_item.push_type,
                       ev_key:  {1'b0, s1_item.key_code}};
        end
        default: begin
        end
      endcase
      if (enq) begin
        rp_next  = rp_adv;
        cnt_next = cnt_base + 1'b1;
      end
    end
  end

  assign dropped = enq && full;
  assign cnt_ext = {5'b0, cnt_next};

  always_comb begin
    result_next.event_type     = ev_type;
    result_next.event_key      = ev_key;
    result_next.key_pressed    = pressed_after;
    result_next.queue_empty    = cnt_next == '0;
    result_next.queue_count    = cnt_ext[4:0];
    result_next.dropped_oldest = dropped;
  end

  kevq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (enq),
    .waddr(wr_ptr),
    .wdata(enq_slot),
    .raddr(rp_next),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      pressed      <= '0;
      rp           <= '0;
      cnt          <= '0;
      byp_hit      <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (flush) begin
        pressed <= '0;
      end else if (set_bit) begin
        pressed[key_idx] <= bit_val;
      end
      rp      <= rp_next;
      cnt     <= cnt_next;
      // same-edge write to the head slot is forwarded around the RAM read
      byp_hit <= enq && (wr_ptr == rp_next);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (s1_fire) begin
      result <= result_next;
    end
    byp_data <= enq_slot;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("queue count above depth");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_item.opcode == OP_FLUSH |=> cnt == '0 && rp == '0 && pressed == '0)
    else $error("flush left state behind");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    s1_fire && dropped |=> cnt == CNT_FULL)
    else $error("drop did not leave queue full");

endmodule

@@ tb/tb_key_event_queue.sv @@
// Self-checking testbench for key_event_queue: directed plan then random key traffic; each
// beat checked against a typed plan row or a behavioral model of pressed bits and queue.
// Depends on kevq_pkg and the key_event_queue RTL.
module tb_key_event_queue;
  import kevq_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    item_t      it;
    logic [4:0] reps;
    logic       typed;
    result_t    want;
  } plan_row_t;

  localparam int PLAN_LEN = 16;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{OP_POP, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, NO_KEY, 1'b0, 1'b1, 5'd0, 1'b0}},
    '{'{OP_KEY_DOWN, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd1, 1'b0}},
    '{'{OP_KEY_DOWN, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd1, 1'b0}},
    '{'{OP_KEY_DOWN, 8'd255, 2'd3}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd2, 1'b0}},
    '{'{OP_KEY_UP, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b0, 1'b0, 5'd3, 1'b0}},
    '{'{OP_KEY_UP, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b0, 1'b0, 5'd3, 1'b0}},
    '{'{OP_PUSH, 8'd255, 2'd3}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd4, 1'b0}},
    '{'{OP_RSVD5, 8'd255, 2'd1}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd4, 1'b0}},
    '{'{OP_RSVD6, 8'd1, 2'd2}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b0, 1'b0, 5'd4, 1'b0}},
    '{'{OP_RSVD7, 8'd255, 2'd3}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd4, 1'b0}},
    '{'{OP_POP, 8'd255, 2'd0}, 5'd1, 1'b1, '{EV_DOWN, 9'd0, 1'b1, 1'b0, 5'd3, 1'b0}},
    '{'{OP_FLUSH, 8'd255, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b0, 1'b1, 5'd0, 1'b0}},
    '{'{OP_POP, 8'd0, 2'd0}, 5'd1, 1'b1, '{EV_NONE, NO_KEY, 1'b0, 1'b1, 5'd0, 1'b0}},
    '{'{OP_PUSH, 8'd128, 2'd2}, 5'd16, 1'b0, '0},
    '{'{OP_KEY_DOWN, 8'd7, 2'd0}, 5'd1, 1'b1, '{EV_NONE, 9'd0, 1'b1, 1'b0, 5'd16, 1'b1}},
    '{'{OP_POP, 8'd7, 2'd0}, 5'd1, 1'b1, '{EV_UP, 9'd128, 1'b1, 1'b0, 5'd15, 1'b0}}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic [NUM_KEYS_DEF-1:0] pressed_map = '0;
  slot_t       event_log [$];
  result_t     awaited_reports [$];
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;

  key_event_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic logic log_event(logic [1:0] ev_type, logic [7:0] key);
    logic dropped;
    dropped = 1'b0;
    if (event_log.size() >= QUEUE_DEPTH_DEF) begin
      void'(event_log.pop_front());
      dropped = 1'b1;
    end
    event_log.push_back('{ev_type, {1'b0, key}});
    return dropped;
  endfunction

  function automatic result_t step_key_state(item_t it);
    result_t r;
    slot_t   s;
    r = '0;
    case (it.opcode)
      OP_KEY_DOWN: begin
        if (!pressed_map[it.key_code]) begin
          pressed_map[it.key_code] = 1'b1;
          r.dropped_oldest = log_event(EV_DOWN, it.key_code);
        end
      end
      OP_KEY_UP: begin
        if (pressed_map[it.key_code]) begin
          pressed_map[it.key_code] = 1'b0;
          r.dropped_oldest = log_event(EV_UP, it.key_code);
        end
      end
      OP_POP: begin
        if (event_log.size() > 0) begin
          s = event_log.pop_front();
          r.event_type = s.ev_type;
          r.event_key  = s.ev_key;
        end else begin
          r.event_type = EV_NONE;
          r.event_key  = NO_KEY;
        end
      end
      OP_FLUSH: begin
        pressed_map = '0;
        event_log.delete();
      end
      OP_PUSH: begin
        r.dropped_oldest = log_event((it.push_type == EV_BAD) ? EV_NONE : it.push_type,
                                     it.key_code);
      end
      default: ;
    endcase
    r.key_pressed = pressed_map[it.key_code];
    r.queue_empty = (event_log.size() == 0);
    r.queue_count = 5'(event_log.size());
    return r;
  endfunction

  task automatic offer(item_t it, logic typed, result_t want);
    result_t predicted;
    bit      idle_ok;
    idle_ok = !(beats_sent >= 250 && beats_sent < 350);
    while (idle_ok && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predicted = step_key_state(it);
    awaited_reports.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  initial begin
    item_t       it;
    int unsigned pop_pct;
    int unsigned roll;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) begin
      for (int r = 0; r < PLAN[i].reps; r++) begin
        offer(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
      end
    end

    // pop share changes in bursts so the queue both drains and overflows
    pop_pct = 30;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) pop_pct = $urandom_range(10, 60);
      roll = $urandom_range(99);
      it.key_code  = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
      it.push_type = 2'($urandom);
      if (roll < 2)
        it.opcode = OP_FLUSH;
      else if (roll < 5)
        it.opcode = 3'($urandom_range(5, 7));
      else if (roll < 5 + pop_pct)
        it.opcode = OP_POP;
      else if (roll < 20 + pop_pct)
        it.opcode = OP_PUSH;
      else
        it.opcode = $urandom_range(1) ? OP_KEY_DOWN : OP_KEY_UP;
      offer(it, 1'b0, '0);
    end
    item_valid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up, one clean stretch
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 300 && cyc < 420)
        result_ready <= 1'b0;
      else if (cyc >= 600 && cyc < 800)
        result_ready <= 1'b1;
      else
        result_ready <= ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && result_ready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: result beat with none expected, actual %p", $time, result);
        mismatches++;
      end else begin
        e = awaited_reports.pop_front();
        if (result.event_type !== e.event_type) begin
          $display("%0t: event_type expected %0d actual %0d", $time, e.event_type,
                   result.event_type);
          mismatches++;
        end
        if (result.event_key !== e.event_key) begin
          $display("%0t: event_key expected %0d actual %0d", $time, e.event_key,
                   result.event_key);
          mismatches++;
        end
        if (result.key_pressed !== e.key_pressed) begin
          $display("%0t: key_pressed expected %0d actual %0d", $time, e.key_pressed,
                   result.key_pressed);
          mismatches++;
        end
        if (result.queue_empty !== e.queue_empty) begin
          $display("%0t: queue_empty expected %0d actual %0d", $time, e.queue_empty,
                   result.queue_empty);
          mismatches++;
        end
        if (result.queue_count !== e.queue_count) begin
          $display("%0t: queue_count expected %0d actual %0d", $time, e.queue_count,
                   result.queue_count);
          mismatches++;
        end
        if (result.dropped_oldest !== e.dropped_oldest) begin
          $display("%0t: dropped_oldest expected %0d actual %0d", $time, e.dropped_oldest,
                   result.dropped_oldest);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
